@@ hdl/qca_pkg.sv @@
package qca_pkg;

  localparam logic [2:0] SEQ_XYZ = 3'd0;
  localparam logic [2:0] SEQ_ZYX = 3'd1;
  localparam logic [2:0] SEQ_ZXY = 3'd2;
  localparam logic [2:0] SEQ_YZX = 3'd3;
  localparam logic [2:0] SEQ_YXZ = 3'd4;
  localparam logic [2:0] SEQ_XZY = 3'd5;

  localparam int ROOT_STEPS = 31;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [17:0] LIM_FULL = 18'sd25736;
  localparam logic signed [17:0] LIM_HALF = 18'sd12868;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [33:0] n0;
    logic signed [33:0] d0;
    logic signed [33:0] n2;
    logic signed [33:0] d2;
    logic signed [31:0] s;
    logic clamped;
  } front_item_t;

  typedef struct packed {
    front_item_t item;
    logic [61:0] v;
    logic [61:0] res;
  } root_stage_t;

  typedef struct packed {
    logic signed [36:0] x;
    logic signed [36:0] y;
    logic signed [33:0] z;
    logic zero;
  } lane_t;

  typedef struct packed {
    lane_t [2:0] lane;
    logic clamped;
  } rot_stage_t;

endpackage

@@ hdl/qca_if.sv @@
interface qca_quat_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qca_angle_if;
  logic valid;
  logic ready;
  logic signed [15:0] first_angle;
  logic signed [14:0] second_angle;
  logic signed [15:0] third_angle;
  logic clamped;
  modport source(output valid, first_angle, second_angle, third_angle, clamped,
                 input ready);
  modport sink(input valid, first_angle, second_angle, third_angle, clamped,
               output ready);
endinterface

@@ hdl/qca_front.sv @@
module qca_front (
  input  logic clk,
  input  logic rst,
  input  logic [2:0] sequence_sel,
  qca_quat_if.sink quat,
  output logic out_valid,
  input  logic out_ready,
  output qca_pkg::front_item_t out_item
);
  import qca_pkg::*;

  logic v1;
  logic v2;
  logic en;
  logic signed [31:0] pww, pxx, pyy, pzz, pwx, pwy, pwz, pxy, pxz, pyz;
  logic signed [33:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
  logic signed [33:0] sraw;
  front_item_t item_next;

  assign en = !v2 || out_ready;
  assign quat.ready = en;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= quat.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pww <= 32'(quat.quat_w * quat.quat_w);
      pxx <= 32'(quat.quat_x * quat.quat_x);
      pyy <= 32'(quat.quat_y * quat.quat_y);
      pzz <= 32'(quat.quat_z * quat.quat_z);
      pwx <= 32'(quat.quat_w * quat.quat_x);
      pwy <= 32'(quat.quat_w * quat.quat_y);
      pwz <= 32'(quat.quat_w * quat.quat_z);
      pxy <= 32'(quat.quat_x * quat.quat_y);
      pxz <= 32'(quat.quat_x * quat.quat_z);
      pyz <= 32'(quat.quat_y * quat.quat_z);
      out_item <= item_next;
    end
  end

  always_comb begin
    ww = 34'(pww); xx = 34'(pxx); yy = 34'(pyy); zz = 34'(pzz);
    wx = 34'(pwx); wy = 34'(pwy); wz = 34'(pwz);
    xy = 34'(pxy); xz = 34'(pxz); yz = 34'(pyz);
    unique case (sequence_sel)
      SEQ_ZYX: begin
        item_next.n2 = (yz + wx) <<< 1; item_next.d2 = zz - yy - xx + ww;
        sraw = (wy - xz) <<< 1;
        item_next.n0 = (xy + wz) <<< 1; item_next.d0 = xx + ww - zz - yy;
      end
      SEQ_ZXY: begin
        item_next.n2 = (wy - xz) <<< 1; item_next.d2 = zz - yy - xx + ww;
        sraw = (yz + wx) <<< 1;
        item_next.n0 = (wz - xy) <<< 1; item_next.d0 = ww - xx - zz + yy;
      end
      SEQ_YZX: begin
        item_next.n2 = (wx - yz) <<< 1; item_next.d2 = yy - zz - xx + ww;
        sraw = (xy + wz) <<< 1;
        item_next.n0 = (wy - xz) <<< 1; item_next.d0 = xx + ww - zz - yy;
      end
      SEQ_YXZ: begin
        item_next.n2 = (xy + wz) <<< 1; item_next.d2 = yy - zz - xx + ww;
        sraw = (wx - yz) <<< 1;
        item_next.n0 = (xz + wy) <<< 1; item_next.d0 = ww - xx + zz - yy;
      end
      SEQ_XZY: begin
        item_next.n2 = (xz + wy) <<< 1; item_next.d2 = xx - zz - yy + ww;
        sraw = (wz - xy) <<< 1;
        item_next.n0 = (yz + wx) <<< 1; item_next.d0 = ww - xx - zz + yy;
      end
      default: begin
        item_next.n2 = (wz - xy) <<< 1; item_next.d2 = xx - zz - yy + ww;
        sraw = (xz + wy) <<< 1;
        item_next.n0 = (wx - yz) <<< 1; item_next.d0 = ww - xx + zz - yy;
      end
    endcase
    item_next.clamped = 1'b0;
    if (sraw > ONE_Q30) begin
      sraw = ONE_Q30;
      item_next.clamped = 1'b1;
    end else if (sraw < -ONE_Q30) begin
      sraw = -ONE_Q30;
      item_next.clamped = 1'b1;
    end
    item_next.s = sraw[31:0];
  end
endmodule

@@ hdl/qca_queue.sv @@
module qca_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  qca_pkg::front_item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output qca_pkg::front_item_t out_item
);
  import qca_pkg::*;

  front_item_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0] count;
  logic push;
  logic pop;

  assign in_ready = count != (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push = in_valid && in_ready;
  assign pop = out_ready && out_valid;
  assign out_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end
endmodule

@@ hdl/qca_back.sv @@
module qca_back #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  qca_pkg::front_item_t in_item,
  qca_angle_if.source angles
);
  import qca_pkg::*;

  logic en;
  logic mv;
  root_stage_t mst;
  logic rv [ROOT_STEPS];
  root_stage_t rs [ROOT_STEPS];
  logic pv;
  rot_stage_t ps;
  logic cv [CORDIC_ITERATIONS];
  rot_stage_t cs [CORDIC_ITERATIONS];
  logic ov;
  logic [31:0] mag;
  rot_stage_t pre_next;

  function automatic lane_t prerot(input logic signed [36:0] y,
                                   input logic signed [36:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x = x;
    l.y = y;
    l.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x = y; l.y = -x; l.z = HALF_PI_Q30;
      end else begin
        l.x = -y; l.y = x; l.z = -HALF_PI_Q30;
      end
    end
    return l;
  endfunction

  function automatic logic signed [17:0] to_q13(input lane_t l,
                                                input logic signed [17:0] lim);
    logic signed [34:0] t;
    logic signed [17:0] r;
    t = 35'(l.z) + 35'sd65536;
    r = 18'(t >>> 17);
    if (l.zero) r = '0;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  assign en = !ov || angles.ready;
  assign in_ready = en;
  assign angles.valid = ov;
  assign mag = in_item.s[31] ? 32'(-in_item.s) : 32'(in_item.s);

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (en) begin
      mv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mst.item <= in_item;
      mst.v <= (62'd1 << 60) - 62'(mag[30:0] * mag[30:0]);
      mst.res <= '0;
    end
  end

  genvar k;
  generate
    for (k = 0; k < ROOT_STEPS; k++) begin : g_root
      root_stage_t pin;
      logic pvin;
      logic [61:0] tmp;
      if (k == 0) begin : g_first
        assign pin = mst;
        assign pvin = mv;
      end else begin : g_next
        assign pin = rs[k-1];
        assign pvin = rv[k-1];
      end
      assign tmp = pin.res + (62'd1 << (60 - 2 * k));
      always_ff @(posedge clk) begin
        if (rst) begin
          rv[k] <= 1'b0;
        end else if (en) begin
          rv[k] <= pvin;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rs[k].item <= pin.item;
          if (pin.v >= tmp) begin
            rs[k].v <= pin.v - tmp;
            rs[k].res <= (pin.res >> 1) + (62'd1 << (60 - 2 * k));
          end else begin
            rs[k].v <= pin.v;
            rs[k].res <= pin.res >> 1;
          end
        end
      end
    end
  endgenerate

  always_comb begin
    pre_next.lane[0] = prerot(37'(rs[ROOT_STEPS-1].item.n0),
                              37'(rs[ROOT_STEPS-1].item.d0));
    pre_next.lane[1] = prerot(37'(rs[ROOT_STEPS-1].item.s),
                              37'($signed({1'b0, rs[ROOT_STEPS-1].res[31:0]})));
    pre_next.lane[2] = prerot(37'(rs[ROOT_STEPS-1].item.n2),
                              37'(rs[ROOT_STEPS-1].item.d2));
    pre_next.clamped = rs[ROOT_STEPS-1].item.clamped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= rv[ROOT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) ps <= pre_next;
  end

  genvar j;
  generate
    for (j = 0; j < CORDIC_ITERATIONS; j++) begin : g_rot
      rot_stage_t pin;
      logic pvin;
      rot_stage_t nxt;
      if (j == 0) begin : g_first
        assign pin = ps;
        assign pvin = pv;
      end else begin : g_next
        assign pin = cs[j-1];
        assign pvin = cv[j-1];
      end
      always_comb begin
        for (int m = 0; m < 3; m++) begin
          nxt.lane[m].zero = pin.lane[m].zero;
          if (pin.lane[m].y > 0) begin
            nxt.lane[m].x = pin.lane[m].x + (pin.lane[m].y >>> j);
            nxt.lane[m].y = pin.lane[m].y - (pin.lane[m].x >>> j);
            nxt.lane[m].z = pin.lane[m].z + 34'(ATAN_TAB[j]);
          end else begin
            nxt.lane[m].x = pin.lane[m].x - (pin.lane[m].y >>> j);
            nxt.lane[m].y = pin.lane[m].y + (pin.lane[m].x >>> j);
            nxt.lane[m].z = pin.lane[m].z - 34'(ATAN_TAB[j]);
          end
        end
        nxt.clamped = pin.clamped;
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          cv[j] <= 1'b0;
        end else if (en) begin
          cv[j] <= pvin;
        end
      end
      always_ff @(posedge clk) begin
        if (en) cs[j] <= nxt;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= cv[CORDIC_ITERATIONS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angles.first_angle <= 16'(to_q13(cs[CORDIC_ITERATIONS-1].lane[0], LIM_FULL));
      angles.second_angle <= 15'(to_q13(cs[CORDIC_ITERATIONS-1].lane[1], LIM_HALF));
      angles.third_angle <= 16'(to_q13(cs[CORDIC_ITERATIONS-1].lane[2], LIM_FULL));
      angles.clamped <= cs[CORDIC_ITERATIONS-1].clamped;
    end
  end
endmodule

@@ hdl/quaternion_to_cardan_angles_top.sv @@
// Throughput: one request per cycle while the angles output is not stalled,
// set by the fully pipelined square root (31 stages) and the three CORDIC
// lanes (one stage per iteration).
// Reset (rst, synchronous) empties all pipeline stages and the queue and sets
// the rotation sequence to xyz.
module quaternion_to_cardan_angles_top #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [2:0] cfg_wdata,
  qca_quat_if.sink quat,
  qca_angle_if.source angles
);
  import qca_pkg::*;

  logic [2:0] rotation_sequence;
  logic f_valid;
  logic f_ready;
  front_item_t f_item;
  logic q_valid;
  logic q_ready;
  front_item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_sequence <= SEQ_XYZ;
    end else if (cfg_we) begin
      rotation_sequence <= cfg_wdata;
    end
  end

  qca_front u_front (
    .clk(clk), .rst(rst), .sequence_sel(rotation_sequence), .quat(quat),
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  qca_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  qca_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .angles(angles)
  );
endmodule
